// ----- rtl/i2c_rts_pkg.sv -----
package i2c_rts_pkg;

	localparam int BUF_DEPTH_DEF = 16;
	localparam int BYTE_W        = 8;

	// item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_EVENT = 2'd1;
	localparam logic [1:0] KIND_LOAD  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_BUSY     = 2'd1;
	localparam logic [1:0] ST_IGNORED  = 2'd2;

	// acknowledge control codes
	localparam logic [1:0] ACK_NONE = 2'd0;
	localparam logic [1:0] ACK_ON   = 2'd1;
	localparam logic [1:0] ACK_NACK = 2'd2;

	// status flag bit positions
	localparam int FLAG_SB   = 0;
	localparam int FLAG_ADDR = 1;
	localparam int FLAG_TXE  = 2;
	localparam int FLAG_RXNE = 3;
	localparam int FLAG_BTF  = 4;

	// direction bit appended to the device address
	localparam logic DIR_WRITE = 1'b0;
	localparam logic DIR_READ  = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] status_flags;
		logic [7:0] data_byte;
		logic [6:0] dev_address;
		logic [7:0] reg_offset;
		logic       is_read;
		logic [4:0] byte_count;
		logic [3:0] buf_index;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       make_start;
		logic       make_stop;
		logic [1:0] ack_control;
		logic       buffer_irq_on;
		logic       read_valid;
		logic [3:0] read_index;
		logic [7:0] read_byte;
		logic       done_res;
	} rsp_item_t;

	typedef struct packed {
		logic       busy;
		logic       reg_done;
		logic       buf_ev;
		logic [4:0] byte_cnt;
		logic [6:0] target_addr;
		logic [7:0] target_reg;
		logic       read_mode;
		logic [4:0] xfer_len;
	} seq_state_t;

endpackage

// ----- rtl/i2c_rts_ram.sv -----
module i2c_rts_ram #(
	parameter int WIDTH = i2c_rts_pkg::BYTE_W,
	parameter int DEPTH = i2c_rts_pkg::BUF_DEPTH_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/i2c_rts_core.sv -----
module i2c_rts_core #(
	parameter int BUF_DEPTH = i2c_rts_pkg::BUF_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  i2c_rts_pkg::req_item_t req,
	output i2c_rts_pkg::rsp_item_t res
);

	localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam logic [8:0] DEPTH_9 = 9'(BUF_DEPTH);

	i2c_rts_pkg::seq_state_t st_q;
	i2c_rts_pkg::seq_state_t st_d;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [7:0]       wdata;
	logic [IDX_W-1:0] raddr;
	logic [7:0]       ram_rdata;
	logic             byp_valid_q;
	logic [7:0]       byp_data_q;
	logic [7:0]       buf_byte;

	logic [8:0] cnt_w;
	logic [8:0] nxt_cnt_w;
	logic [8:0] idx_w;
	logic [8:0] count_w;
	logic [5:0] cnt_p1;
	logic [5:0] cnt_p2;
	logic [5:0] len_6;
	logic       cnt_spent;
	logic       fl_sb, fl_addr, fl_txe, fl_rxne, fl_btf;

	i2c_rts_ram #(
		.WIDTH(i2c_rts_pkg::BYTE_W),
		.DEPTH(BUF_DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// the RAM always holds the entry at the current byte counter; a write in the
	// same edge to that entry is forwarded
	assign buf_byte = byp_valid_q ? byp_data_q : ram_rdata;

	assign cnt_w     = {4'b0, st_q.byte_cnt};
	assign idx_w     = {5'b0, req.buf_index};
	assign count_w   = {4'b0, req.byte_count};
	assign cnt_p1    = {1'b0, st_q.byte_cnt} + 6'd1;
	assign cnt_p2    = {1'b0, st_q.byte_cnt} + 6'd2;
	assign len_6     = {1'b0, st_q.xfer_len};
	assign cnt_spent = (st_q.byte_cnt >= st_q.xfer_len) || (cnt_w >= DEPTH_9);

	assign fl_sb   = req.status_flags[i2c_rts_pkg::FLAG_SB];
	assign fl_addr = req.status_flags[i2c_rts_pkg::FLAG_ADDR];
	assign fl_txe  = req.status_flags[i2c_rts_pkg::FLAG_TXE];
	assign fl_rxne = req.status_flags[i2c_rts_pkg::FLAG_RXNE];
	assign fl_btf  = req.status_flags[i2c_rts_pkg::FLAG_BTF];

	always_comb begin
		st_d  = st_q;
		res   = '0;
		we    = 1'b0;
		waddr = cnt_w[IDX_W-1:0];
		wdata = req.data_byte;
		unique case (req.kind)
			i2c_rts_pkg::KIND_START: begin
				if (st_q.busy) begin
					res.status = i2c_rts_pkg::ST_BUSY;
				end else begin
					st_d.busy        = 1'b1;
					st_d.byte_cnt    = '0;
					st_d.reg_done    = 1'b0;
					st_d.target_addr = req.dev_address;
					st_d.target_reg  = req.reg_offset;
					st_d.read_mode   = req.is_read;
					st_d.xfer_len    = (count_w > DEPTH_9) ? 5'(BUF_DEPTH) : req.byte_count;
					res.ack_control  = i2c_rts_pkg::ACK_ON;
					res.make_start   = 1'b1;
				end
			end
			i2c_rts_pkg::KIND_EVENT: begin
				if (!st_q.busy) begin
					res.status = i2c_rts_pkg::ST_IGNORED;
				end else begin
					priority if (fl_sb) begin
						res.send_valid = 1'b1;
						res.send_byte  = {st_q.target_addr,
							st_q.reg_done ? i2c_rts_pkg::DIR_READ : i2c_rts_pkg::DIR_WRITE};
					end else if (fl_addr) begin
						st_d.buf_ev = 1'b1;
						if (st_q.reg_done && st_q.xfer_len == 5'd1) begin
							res.ack_control = i2c_rts_pkg::ACK_NACK;
							res.make_stop   = 1'b1;
						end
					end else if (fl_txe && st_q.buf_ev) begin
						if (!st_q.reg_done) begin
							st_d.reg_done = 1'b1;
							if (st_q.xfer_len == 5'd0 || st_q.read_mode) begin
								st_d.buf_ev = 1'b0;
							end
							res.send_valid = 1'b1;
							res.send_byte  = st_q.target_reg;
						end else if (!st_q.read_mode) begin
							if (cnt_spent) begin
								st_d.buf_ev = 1'b0;
							end else begin
								if (cnt_p1 == len_6) begin
									st_d.buf_ev = 1'b0;
								end
								res.send_valid = 1'b1;
								res.send_byte  = buf_byte;
								st_d.byte_cnt  = cnt_p1[4:0];
							end
						end
					end else if (fl_rxne) begin
						if (!cnt_spent) begin
							we             = 1'b1;
							res.read_valid = 1'b1;
							res.read_index = st_q.byte_cnt[3:0];
							res.read_byte  = req.data_byte;
							st_d.byte_cnt  = cnt_p1[4:0];
							// nack the byte before the last, finish on the last
							if (cnt_p2 == len_6) begin
								res.ack_control = i2c_rts_pkg::ACK_NACK;
								res.make_stop   = 1'b1;
							end else if (cnt_p1 == len_6) begin
								res.done_res = 1'b1;
								st_d.busy    = 1'b0;
							end
						end
					end else if (fl_btf && fl_txe) begin
						if (st_q.read_mode && st_q.xfer_len != 5'd0) begin
							res.make_start = 1'b1;
						end else begin
							res.make_stop = 1'b1;
							res.done_res  = 1'b1;
							st_d.busy     = 1'b0;
						end
					end else begin
						res.status = i2c_rts_pkg::ST_ACCEPTED;
					end
				end
			end
			i2c_rts_pkg::KIND_LOAD: begin
				if (idx_w < DEPTH_9) begin
					we    = 1'b1;
					waddr = idx_w[IDX_W-1:0];
				end
			end
			default: begin
				res.status = i2c_rts_pkg::ST_IGNORED;
			end
		endcase
		res.buffer_irq_on = st_d.buf_ev;
		we = we && accept;
	end

	assign nxt_cnt_w = accept ? {4'b0, st_d.byte_cnt} : cnt_w;
	assign raddr     = nxt_cnt_w[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			byp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q <= st_d;
			end
			byp_valid_q <= we && (waddr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wdata;
	end

endmodule

// ----- rtl/i2c_rts_obuf.sv -----
module i2c_rts_obuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  i2c_rts_pkg::rsp_item_t push_item,
	input  logic                   rsp_stall,
	output logic                   rsp_valid,
	output i2c_rts_pkg::rsp_item_t rsp,
	output logic                   full
);

	logic                   out_valid_q;
	i2c_rts_pkg::rsp_item_t out_q;
	logic                   skid_valid_q;
	i2c_rts_pkg::rsp_item_t skid_q;
	logic                   out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				// drain the skid entry first; no push can arrive while it is full
				out_valid_q  <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : push_item;
		end
		if (!out_free && push) begin
			skid_q <= push_item;
		end
	end

endmodule

// ----- rtl/i2c_master_register_transfer_sequencer.sv -----
// Each accepted transaction's result is registered in the output buffer and presented on rsp.
// Throughput: one item per cycle; a two-entry output buffer keeps req open while
// one result waits, and req stalls only when both entries are held.
// The write buffer is read at the next byte counter value, with same-edge writes forwarded.
// Reset (arst_n low) clears the sequencer state and output buffer; write buffer
// contents are undefined until loaded or received.
module i2c_master_register_transfer_sequencer #(
	parameter int BUF_DEPTH = i2c_rts_pkg::BUF_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  i2c_rts_pkg::req_item_t req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output i2c_rts_pkg::rsp_item_t rsp
);

	logic                   accept;
	i2c_rts_pkg::rsp_item_t res;

	assign accept = req_valid && !req_stall;

	i2c_rts_core #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.req   (req),
		.res   (res)
	);

	i2c_rts_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_item(res),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.full     (req_stall)
	);

	a_stall_needs_held_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("req stalled with no result held");

	a_accept_fills_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !rsp_valid) |=> rsp_valid)
		else $error("accepted transaction produced no result");

	a_single_byte_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.send_valid && rsp.read_valid))
		else $error("send and read reported in one result");

	a_done_clears_start: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.done_res) |-> (!rsp.make_start && rsp.ack_control != i2c_rts_pkg::ACK_ON))
		else $error("completion combined with a start request");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [4:0] F_NONE = 5'b00000;
	localparam logic [4:0] F_SB   = 5'(1 << i2c_rts_pkg::FLAG_SB);
	localparam logic [4:0] F_ADDR = 5'(1 << i2c_rts_pkg::FLAG_ADDR);
	localparam logic [4:0] F_TXE  = 5'(1 << i2c_rts_pkg::FLAG_TXE);
	localparam logic [4:0] F_RXNE = 5'(1 << i2c_rts_pkg::FLAG_RXNE);
	localparam logic [4:0] F_BTF  = 5'(1 << i2c_rts_pkg::FLAG_BTF);
	localparam logic [4:0] F_ALL  = 5'b11111;

	localparam int DEPTH        = i2c_rts_pkg::BUF_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 850;
	localparam int LONG_HOLD    = 80;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   req_valid;
	logic                   req_stall;
	i2c_rts_pkg::req_item_t req;
	logic                   rsp_valid;
	logic                   rsp_stall;
	i2c_rts_pkg::rsp_item_t rsp;

	i2c_master_register_transfer_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sequencer state as the checker sees it
	logic       m_busy;
	logic       m_reg_done;
	logic       m_buf_ev;
	logic       m_read;
	int         m_cnt;
	int         m_len;
	logic [6:0] m_addr;
	logic [7:0] m_reg;
	logic [7:0] m_wbuf [DEPTH];
	bit         m_written [DEPTH];

	i2c_rts_pkg::rsp_item_t pending_bus_rsp [$];
	i2c_rts_pkg::rsp_item_t predicted_rsp;
	bit                     row_typed;
	i2c_rts_pkg::rsp_item_t row_rsp;
	bit                     hold_req;
	int                     mismatches;
	int                     gen_phase;
	bit                     gen_restarted;
	int                     burst_left;
	int                     gapless_left;

	i2c_rts_pkg::req_item_t dir_req [$];
	bit                     dir_typed [$];
	i2c_rts_pkg::rsp_item_t dir_rsp [$];

	function automatic i2c_rts_pkg::rsp_item_t predict_bus_step(i2c_rts_pkg::req_item_t it);
		i2c_rts_pkg::rsp_item_t r;
		logic [4:0]             f;
		logic [7:0]             d;
		int                     n;
		r = '0;
		f = it.status_flags;
		d = it.data_byte;
		case (it.kind)
			i2c_rts_pkg::KIND_START: begin
				if (m_busy) begin
					r.status = i2c_rts_pkg::ST_BUSY;
				end else begin
					m_busy = 1'b1;
					m_cnt = 0;
					m_reg_done = 1'b0;
					m_addr = it.dev_address;
					m_reg = it.reg_offset;
					m_read = it.is_read;
					n = it.byte_count;
					if (n > DEPTH)
						n = DEPTH;
					m_len = n;
					r.ack_control = i2c_rts_pkg::ACK_ON;
					r.make_start = 1'b1;
				end
			end
			i2c_rts_pkg::KIND_EVENT: begin
				if (!m_busy) begin
					r.status = i2c_rts_pkg::ST_IGNORED;
				end else if (f[i2c_rts_pkg::FLAG_SB]) begin
					r.send_valid = 1'b1;
					r.send_byte = {m_addr,
						m_reg_done ? i2c_rts_pkg::DIR_READ : i2c_rts_pkg::DIR_WRITE};
				end else if (f[i2c_rts_pkg::FLAG_ADDR]) begin
					m_buf_ev = 1'b1;
					if (m_reg_done && m_len == 1) begin
						r.ack_control = i2c_rts_pkg::ACK_NACK;
						r.make_stop = 1'b1;
					end
				end else if (f[i2c_rts_pkg::FLAG_TXE] && m_buf_ev) begin
					if (!m_reg_done) begin
						m_reg_done = 1'b1;
						if (m_len == 0 || m_read)
							m_buf_ev = 1'b0;
						r.send_valid = 1'b1;
						r.send_byte = m_reg;
					end else if (!m_read) begin
						if (m_cnt >= m_len || m_cnt >= DEPTH) begin
							m_buf_ev = 1'b0;
						end else begin
							if (m_cnt + 1 == m_len)
								m_buf_ev = 1'b0;
							r.send_valid = 1'b1;
							r.send_byte = m_wbuf[m_cnt];
							m_cnt++;
						end
					end
				end else if (f[i2c_rts_pkg::FLAG_RXNE]) begin
					if (m_cnt < m_len && m_cnt < DEPTH) begin
						m_wbuf[m_cnt] = d;
						m_written[m_cnt] = 1'b1;
						r.read_valid = 1'b1;
						r.read_index = m_cnt[3:0];
						r.read_byte = d;
						m_cnt++;
						if (m_cnt + 1 == m_len) begin
							r.ack_control = i2c_rts_pkg::ACK_NACK;
							r.make_stop = 1'b1;
						end else if (m_cnt == m_len) begin
							r.done_res = 1'b1;
							m_busy = 1'b0;
						end
					end
				end else if (f[i2c_rts_pkg::FLAG_BTF] && f[i2c_rts_pkg::FLAG_TXE]) begin
					if (m_read && m_len > 0) begin
						r.make_start = 1'b1;
					end else begin
						r.make_stop = 1'b1;
						r.done_res = 1'b1;
						m_busy = 1'b0;
					end
				end
			end
			i2c_rts_pkg::KIND_LOAD: begin
				m_wbuf[it.buf_index] = d;
				m_written[it.buf_index] = 1'b1;
			end
			default: begin
				r.status = i2c_rts_pkg::ST_IGNORED;
			end
		endcase
		r.buffer_irq_on = m_buf_ev;
		return r;
	endfunction

	// mostly well-formed transactions, with noise mixed in
	function automatic i2c_rts_pkg::req_item_t next_bus_item();
		i2c_rts_pkg::req_item_t it;
		int                     pick;
		it.kind = 2'($urandom_range(0, 3));
		it.status_flags = 5'($urandom_range(0, 31));
		it.data_byte = 8'($urandom_range(0, 255));
		it.dev_address = 7'($urandom_range(0, 127));
		it.reg_offset = 8'($urandom_range(0, 255));
		it.is_read = 1'($urandom_range(0, 1));
		it.byte_count = 5'($urandom_range(0, 31));
		it.buf_index = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (!m_busy) begin
			if (pick < 70) begin
				it.kind = i2c_rts_pkg::KIND_START;
				if ($urandom_range(0, 9) != 0)
					it.byte_count = 5'($urandom_range(0, 4));
			end else if (pick < 88) begin
				it.kind = i2c_rts_pkg::KIND_LOAD;
			end
		end else if (pick < 88) begin
			it.kind = i2c_rts_pkg::KIND_EVENT;
			if (gen_phase == 0) begin
				it.status_flags |= F_SB;
				gen_phase = 1;
			end else if (gen_phase == 1) begin
				it.status_flags = (it.status_flags & ~F_SB) | F_ADDR;
				gen_phase = 2;
			end else if (!m_reg_done) begin
				it.status_flags = F_TXE | (it.status_flags & (F_RXNE | F_BTF));
			end else if (m_read && gen_restarted) begin
				it.status_flags = F_RXNE | (it.status_flags & F_BTF);
			end else if (!m_read && m_buf_ev && m_cnt < m_len) begin
				it.status_flags = F_TXE | (it.status_flags & (F_RXNE | F_BTF));
			end else begin
				it.status_flags = F_TXE | F_BTF;
				if (m_read && m_len > 0) begin
					gen_restarted = 1'b1;
					gen_phase = 0;
				end
			end
		end else if (pick < 94) begin
			it.kind = i2c_rts_pkg::KIND_LOAD;
		end
		if (it.kind == i2c_rts_pkg::KIND_START && !m_busy) begin
			gen_phase = 0;
			gen_restarted = 1'b0;
		end
		// never send a buffer byte that was not loaded: load it instead
		if (it.kind == i2c_rts_pkg::KIND_EVENT && m_busy
				&& !it.status_flags[i2c_rts_pkg::FLAG_SB]
				&& !it.status_flags[i2c_rts_pkg::FLAG_ADDR]
				&& it.status_flags[i2c_rts_pkg::FLAG_TXE] && m_buf_ev
				&& m_reg_done && !m_read && m_cnt < m_len && m_cnt < DEPTH
				&& !m_written[m_cnt]) begin
			it.kind = i2c_rts_pkg::KIND_LOAD;
			it.buf_index = m_cnt[3:0];
		end
		return it;
	endfunction

	function automatic i2c_rts_pkg::req_item_t mk_req(logic [1:0] kind, logic [4:0] flags,
			logic [7:0] data, logic [6:0] dev, logic [7:0] regad, logic rd, logic [4:0] cnt,
			logic [3:0] idx);
		i2c_rts_pkg::req_item_t it;
		it.kind = kind;
		it.status_flags = flags;
		it.data_byte = data;
		it.dev_address = dev;
		it.reg_offset = regad;
		it.is_read = rd;
		it.byte_count = cnt;
		it.buf_index = idx;
		return it;
	endfunction

	function automatic i2c_rts_pkg::rsp_item_t mk_rsp(logic [1:0] status, logic sv,
			logic [7:0] sb, logic start, logic stop, logic [1:0] ack, logic irq);
		i2c_rts_pkg::rsp_item_t r;
		r = '0;
		r.status = status;
		r.send_valid = sv;
		r.send_byte = sb;
		r.make_start = start;
		r.make_stop = stop;
		r.ack_control = ack;
		r.buffer_irq_on = irq;
		return r;
	endfunction

	task automatic add_row(i2c_rts_pkg::req_item_t it, bit typed, i2c_rts_pkg::rsp_item_t want);
		dir_req.push_back(it);
		dir_typed.push_back(typed);
		dir_rsp.push_back(want);
	endtask

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic compare_rsp(i2c_rts_pkg::rsp_item_t got, i2c_rts_pkg::rsp_item_t want);
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
		if (got.send_valid !== want.send_valid)
			report_mismatch($sformatf("send_valid %0b, want %0b", got.send_valid, want.send_valid));
		if (got.send_byte !== want.send_byte)
			report_mismatch($sformatf("send_byte %h, want %h", got.send_byte, want.send_byte));
		if (got.make_start !== want.make_start)
			report_mismatch($sformatf("make_start %0b, want %0b", got.make_start, want.make_start));
		if (got.make_stop !== want.make_stop)
			report_mismatch($sformatf("make_stop %0b, want %0b", got.make_stop, want.make_stop));
		if (got.ack_control !== want.ack_control)
			report_mismatch($sformatf("ack_control %0d, want %0d", got.ack_control,
				want.ack_control));
		if (got.buffer_irq_on !== want.buffer_irq_on)
			report_mismatch($sformatf("buffer_irq_on %0b, want %0b", got.buffer_irq_on,
				want.buffer_irq_on));
		if (got.read_valid !== want.read_valid)
			report_mismatch($sformatf("read_valid %0b, want %0b", got.read_valid, want.read_valid));
		if (got.read_index !== want.read_index)
			report_mismatch($sformatf("read_index %0d, want %0d", got.read_index, want.read_index));
		if (got.read_byte !== want.read_byte)
			report_mismatch($sformatf("read_byte %h, want %h", got.read_byte, want.read_byte));
		if (got.done_res !== want.done_res)
			report_mismatch($sformatf("done_res %0b, want %0b", got.done_res, want.done_res));
	endtask

	// offer one transaction, hold it until taken, then pace the next one
	task automatic offer(i2c_rts_pkg::req_item_t it, bit typed, i2c_rts_pkg::rsp_item_t want);
		req <= it;
		req_valid <= 1'b1;
		row_typed <= typed;
		row_rsp <= want;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		@(negedge clk);
		if (gapless_left > 0) begin
			gapless_left--;
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_bus_rsp.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (pending_bus_rsp.size() == 0)
					report_mismatch("result with nothing expected");
				else
					compare_rsp(rsp, pending_bus_rsp.pop_front());
			end
			if (req_valid && req_stall === 1'b0) begin
				predicted_rsp = predict_bus_step(req);
				pending_bus_rsp.push_back(row_typed ? row_rsp : predicted_rsp);
			end
		end
	end

	initial begin : receiver
		int  seg_left;
		int  stall_pct;
		bit  take_hold;
		seg_left = 0;
		stall_pct = 0;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			take_hold = hold_req;
			@(negedge clk);
			if (take_hold) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
			end
			if (seg_left == 0) begin
				seg_left = $urandom_range(8, 60);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 30;
					default: stall_pct = 75;
				endcase
			end
			seg_left--;
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	initial begin : stimulus
		i2c_rts_pkg::req_item_t it;
		int                     i;
		int                     n_random;
		int                     next_hold;
		int                     next_drain;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		row_typed = 1'b0;
		row_rsp = '0;
		hold_req = 1'b0;
		mismatches = 0;
		m_busy = 1'b0;
		m_reg_done = 1'b0;
		m_buf_ev = 1'b0;
		m_read = 1'b0;
		m_cnt = 0;
		m_len = 0;
		m_addr = '0;
		m_reg = '0;
		for (i = 0; i < DEPTH; i++) begin
			m_wbuf[i] = '0;
			m_written[i] = 1'b0;
		end
		gen_phase = 0;
		gen_restarted = 1'b0;
		burst_left = 0;
		gapless_left = 0;

		// idle sequencer, ignored items, buffer loads at both ends and at index 1
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_ALL, 8'hFF, 7'h7F, 8'hFF, 1'b1, 5'd31, 4'hF),
			1'b1, mk_rsp(i2c_rts_pkg::ST_IGNORED, 1'b0, 8'h00, 1'b0, 1'b0,
			i2c_rts_pkg::ACK_NONE, 1'b0));
		add_row(mk_req(KIND_UNUSED, F_NONE, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b1, mk_rsp(i2c_rts_pkg::ST_IGNORED, 1'b0, 8'h00, 1'b0, 1'b0,
			i2c_rts_pkg::ACK_NONE, 1'b0));
		add_row(mk_req(i2c_rts_pkg::KIND_LOAD, F_NONE, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b1, mk_rsp(i2c_rts_pkg::ST_ACCEPTED, 1'b0, 8'h00, 1'b0, 1'b0,
			i2c_rts_pkg::ACK_NONE, 1'b0));
		add_row(mk_req(i2c_rts_pkg::KIND_LOAD, F_ALL, 8'hFF, 7'h7F, 8'hFF, 1'b1, 5'd31, 4'hF),
			1'b1, mk_rsp(i2c_rts_pkg::ST_ACCEPTED, 1'b0, 8'h00, 1'b0, 1'b0,
			i2c_rts_pkg::ACK_NONE, 1'b0));
		add_row(mk_req(i2c_rts_pkg::KIND_LOAD, F_NONE, 8'hA5, 7'h00, 8'h00, 1'b0, 5'd0, 4'h1),
			1'b0, '0);
		// two-byte write, with a busy start and an extra tx-empty
		add_row(mk_req(i2c_rts_pkg::KIND_START, F_NONE, 8'h00, 7'h7F, 8'hFF, 1'b0, 5'd2, 4'h0),
			1'b1, mk_rsp(i2c_rts_pkg::ST_ACCEPTED, 1'b0, 8'h00, 1'b1, 1'b0,
			i2c_rts_pkg::ACK_ON, 1'b0));
		add_row(mk_req(i2c_rts_pkg::KIND_START, F_NONE, 8'h00, 7'h00, 8'h00, 1'b1, 5'd31, 4'h0),
			1'b1, mk_rsp(i2c_rts_pkg::ST_BUSY, 1'b0, 8'h00, 1'b0, 1'b0,
			i2c_rts_pkg::ACK_NONE, 1'b0));
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_NONE, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_SB | F_BTF, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0,
			4'h0), 1'b1, mk_rsp(i2c_rts_pkg::ST_ACCEPTED, 1'b1, 8'hFE, 1'b0, 1'b0,
			i2c_rts_pkg::ACK_NONE, 1'b0));
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_ALL & ~F_SB, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0,
			4'h0), 1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_TXE, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_TXE | F_RXNE, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0,
			4'h0), 1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_TXE, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_ADDR, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_TXE, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_TXE | F_BTF, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0,
			4'h0), 1'b0, '0);
		// two-byte read through a repeated start
		add_row(mk_req(i2c_rts_pkg::KIND_START, F_NONE, 8'h00, 7'h00, 8'h00, 1'b1, 5'd2, 4'h0),
			1'b1, mk_rsp(i2c_rts_pkg::ST_ACCEPTED, 1'b0, 8'h00, 1'b1, 1'b0,
			i2c_rts_pkg::ACK_ON, 1'b0));
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_SB, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b1, mk_rsp(i2c_rts_pkg::ST_ACCEPTED, 1'b1, 8'h00, 1'b0, 1'b0,
			i2c_rts_pkg::ACK_NONE, 1'b0));
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_ADDR, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_TXE, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_TXE | F_BTF, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0,
			4'h0), 1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_SB, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b1, mk_rsp(i2c_rts_pkg::ST_ACCEPTED, 1'b1, 8'h01, 1'b0, 1'b0,
			i2c_rts_pkg::ACK_NONE, 1'b0));
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_ADDR, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_RXNE, 8'hFF, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b0, '0);
		add_row(mk_req(i2c_rts_pkg::KIND_EVENT, F_RXNE, 8'h00, 7'h00, 8'h00, 1'b0, 5'd0, 4'h0),
			1'b0, '0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < dir_req.size(); i++)
			offer(dir_req[i], dir_typed[i], dir_rsp[i]);
		drain();

		n_random = 0;
		next_hold = 200;
		next_drain = 420;
		while (n_random < RANDOM_ITEMS) begin
			it = next_bus_item();
			if (!(it.kind == KIND_UNUSED || (it.kind == i2c_rts_pkg::KIND_EVENT && !m_busy)))
				n_random++;
			// stall the result side and keep pushing so the input backs up
			if (n_random >= next_hold) begin
				hold_req = 1'b1;
				gapless_left = 60;
				next_hold += 350;
			end
			if (n_random >= next_drain) begin
				drain();
				next_drain += 400;
			end
			offer(it, 1'b0, '0);
		end
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
